/* rtl/core/wsfp_pkg.sv */
// package with the shared types and frame constants of the wheel speed frame parser
package wsfp_pkg;

   // frame format
   localparam logic [7:0] HEADER_BYTE    = 8'hBB;
   localparam logic [7:0] TAIL_BYTE      = 8'h66;
   localparam logic [3:0] INDEX_MAX      = 4'd15;
   localparam logic [3:0] XOR_BYTES      = 4'd7;
   localparam logic [3:0] FRAME_LAST_POS = 4'd8;

   // byte positions inside a frame
   localparam logic [3:0] POS_HEADER     = 4'd0;
   localparam logic [3:0] POS_ADDRESS    = 4'd1;
   localparam logic [3:0] POS_LENGTH     = 4'd2;
   localparam logic [3:0] POS_LEFT_HI    = 4'd3;
   localparam logic [3:0] POS_LEFT_LO    = 4'd4;
   localparam logic [3:0] POS_RIGHT_HI   = 4'd5;
   localparam logic [3:0] POS_RIGHT_LO   = 4'd6;
   localparam logic [3:0] POS_CHECK      = 4'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   typedef struct packed {
      logic              frame_ok;
      logic [7:0]        device_address;
      logic [7:0]        payload_length;
      logic signed [15:0] left_wheel_speed;
      logic signed [15:0] right_wheel_speed;
   } rsp_item_type;

endpackage

/* rtl/core/wheel_speed_frame_parser.sv */
// top level of the wheel speed frame parser
//
// Bytes arrive on the req_ channel, one per transfer, each with frame_end
// marking the last byte of a frame. Each frame end gives one result on the
// rsp_ channel: frame_ok, and when it is set, the device address, length
// byte and both signed wheel speeds; a bad frame reports zero fields.
// Bytes without frame_end give no result.
// A byte is held in the input register, then the frame tracker checks it
// and the result is loaded into the output register, which drives
// rsp_valid and rsp_data.
// One byte is taken every cycle while req_stall is low; the output
// register lets the next bytes of a frame come in while a result waits.
// When rsp_stall holds a result, the block keeps taking bytes until a
// second frame end reaches the input register; it then raises req_stall
// until the waiting result is taken.
// Synchronous reset empties both registers and clears byte count, xor and
// captured fields.
module wheel_speed_frame_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wsfp_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wsfp_pkg::rsp_item_type rsp_data
);
   import wsfp_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         out_free;
   logic         step;

   // the held byte moves on unless it ends a frame and the output holds a stalled result
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_item_ff.frame_end || out_free);
   assign req_stall = in_valid_ff && !step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   wsfp_frame_track u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && in_item_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_item_ff.frame_end) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

`ifndef SYNTHESIS
   // stall comes only from a held byte
   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held byte");

   // a processed frame end always shows up as a result
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step && in_item_ff.frame_end) |=> rsp_valid)
      else $error("frame end produced no result");

   // a byte that does not end a frame never stalls
   a_mid_frame_flows: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_item_ff.frame_end) |-> !req_stall)
      else $error("mid-frame byte stalled");

   // bad frames carry zero fields
   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.frame_ok) |->
         (rsp_data.device_address == 8'd0) && (rsp_data.payload_length == 8'd0) &&
         (rsp_data.left_wheel_speed == 16'sd0) && (rsp_data.right_wheel_speed == 16'sd0))
      else $error("bad frame with nonzero fields");
`endif

endmodule

/* rtl/core/wsfp_frame_track.sv */
// frame tracker: byte count, running xor, field capture and the frame check
module wsfp_frame_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  wsfp_pkg::req_item_type item,
   output wsfp_pkg::rsp_item_type result
);
   import wsfp_pkg::*;

   logic [3:0]  byte_index_ff, byte_index_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic        header_matched_ff, header_matched_in;
   logic [7:0]  address_ff, address_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;
   logic [7:0]  check_ff, check_in;
   logic        frame_ok;

   // capture by position, xor of the leading bytes, saturating count
   always_comb begin
      header_matched_in = header_matched_ff;
      address_in        = address_ff;
      length_in         = length_ff;
      left_in           = left_ff;
      right_in          = right_ff;
      check_in          = check_ff;
      unique case (byte_index_ff)
         POS_HEADER:   header_matched_in = (item.rx_byte == HEADER_BYTE);
         POS_ADDRESS:  address_in        = item.rx_byte;
         POS_LENGTH:   length_in         = item.rx_byte;
         POS_LEFT_HI:  left_in[15:8]     = item.rx_byte;
         POS_LEFT_LO:  left_in[7:0]      = item.rx_byte;
         POS_RIGHT_HI: right_in[15:8]    = item.rx_byte;
         POS_RIGHT_LO: right_in[7:0]     = item.rx_byte;
         POS_CHECK:    check_in          = item.rx_byte;
         default: ;
      endcase

      running_xor_in = running_xor_ff;
      if (byte_index_ff < XOR_BYTES) begin
         running_xor_in = running_xor_ff ^ item.rx_byte;
      end

      byte_index_in = (byte_index_ff == INDEX_MAX) ? INDEX_MAX : byte_index_ff + 4'd1;

      // frame end clears the count, xor and header flag
      if (item.frame_end) begin
         byte_index_in     = '0;
         running_xor_in    = '0;
         header_matched_in = 1'b0;
      end
   end

   // only a ninth byte can close a good frame, and it changes no captured state
   assign frame_ok = (byte_index_ff == FRAME_LAST_POS) && header_matched_ff &&
                     (item.rx_byte == TAIL_BYTE) && (running_xor_ff == check_ff);

   // result fields are zero for a bad frame
   always_comb begin
      result.frame_ok          = frame_ok;
      result.device_address    = frame_ok ? address_ff : 8'd0;
      result.payload_length    = frame_ok ? length_ff  : 8'd0;
      result.left_wheel_speed  = frame_ok ? left_ff    : 16'sd0;
      result.right_wheel_speed = frame_ok ? right_ff   : 16'sd0;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff     <= '0;
         running_xor_ff    <= '0;
         header_matched_ff <= 1'b0;
         address_ff        <= '0;
         length_ff         <= '0;
         left_ff           <= '0;
         right_ff          <= '0;
         check_ff          <= '0;
      end else if (step) begin
         byte_index_ff     <= byte_index_in;
         running_xor_ff    <= running_xor_in;
         header_matched_ff <= header_matched_in;
         address_ff        <= address_in;
         length_ff         <= length_in;
         left_ff           <= left_in;
         right_ff          <= right_in;
         check_ff          <= check_in;
      end
   end

endmodule
